>>> sv/nibble_lut_scan_accumulate_defines.svh
// Assertion macros for the nibble lookup scan accumulator checker.
// No dependencies.
`ifndef NIBBLE_LUT_SCAN_ACCUMULATE_DEFINES_SVH
`define NIBBLE_LUT_SCAN_ACCUMULATE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define NLSA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define NLSA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/nlsa_pkg.sv
// Shared types and constants for the nibble lookup scan accumulator.
// No dependencies.
package nlsa_pkg;

  localparam int LANES       = 32;
  localparam int LUT_ENTRIES = 16;
  localparam int NIB_W       = 4;
  localparam int BYTE_W      = 8;
  localparam int SUM_W       = 16;
  localparam int IDX_W       = 5;
  localparam int WORD_W      = 64;
  localparam int GROUP_LANES = 8;

  localparam logic [IDX_W-1:0] LANE_LAST = IDX_W'(LANES - 1);

  typedef logic [LUT_ENTRIES-1:0][BYTE_W-1:0] lut_t;
  typedef logic [SUM_W-1:0]                   sum_t;
  typedef logic [LANES-1:0][SUM_W-1:0]        sum_arr_t;

  typedef struct packed {
    logic [WORD_W-1:0] code_bytes_lo;
    logic [WORD_W-1:0] code_bytes_hi;
    logic [WORD_W-1:0] table_entries_lo;
    logic [WORD_W-1:0] table_entries_hi;
    logic              final_step;
  } in_t;

  typedef struct packed {
    logic [IDX_W-1:0] lane_index;
    logic [SUM_W-1:0] lane_sum;
    logic             run_end;
  } out_t;

  typedef struct packed {
    logic en;
    logic clr;
  } lane_ctl_t;

endpackage

>>> sv/nlsa_lane.sv
// One accumulation lane: table lookup by a 4-bit code and a wrapping 16-bit sum.
// Depends on nlsa_pkg.
module nlsa_lane import nlsa_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  lane_ctl_t        ctl_i,
  input  logic [NIB_W-1:0] nib_i,
  input  lut_t             lut_i,
  output sum_t             sum_o
);

  sum_t acc_r;
  sum_t acc_nxt;

  assign sum_o = acc_r + {{(SUM_W-BYTE_W){1'b0}}, lut_i[nib_i]};

  always_comb begin
    acc_nxt = acc_r;
    if (ctl_i.en) begin
      acc_nxt = ctl_i.clr ? '0 : sum_o;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

endmodule

>>> sv/nlsa_drain.sv
// Merge stage: captures all lane sums at the end of a scan and streams them out.
// Depends on nlsa_pkg.
module nlsa_drain import nlsa_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     load_i,
  input  sum_arr_t sums_i,
  output logic     busy_o,
  output logic     out_valid,
  input  logic     out_ready,
  output out_t     out_data
);

  sum_arr_t         bank_r;
  logic [IDX_W-1:0] cnt_r;
  logic [IDX_W-1:0] cnt_nxt;
  logic             busy_r;
  logic             busy_nxt;
  logic             xfer;

  assign xfer      = busy_r && out_ready;
  assign busy_o    = busy_r;
  assign out_valid = busy_r;

  assign out_data.lane_index = cnt_r;
  assign out_data.lane_sum   = bank_r[cnt_r];
  assign out_data.run_end    = (cnt_r == LANE_LAST);

  always_comb begin
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (load_i) begin
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (xfer) begin
      cnt_nxt = cnt_r + IDX_W'(1);
      if (cnt_r == LANE_LAST) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      bank_r <= sums_i;
    end
  end

endmodule

>>> sv/nibble_lut_scan_accumulate.sv
// Nibble lookup scan accumulator: 32 lanes add table bytes into 16-bit sums.
// Throughput: one step per cycle; a final step waits while the previous scan's
// 32 sums are still streaming out. The first sum is valid the cycle after
// the final step transfers, then one sum per cycle while out_ready is high.
// Reset (synchronous, rst_n low) clears all sums and the output stream.
// Depends on nlsa_pkg, nlsa_lane and nlsa_drain.
module nibble_lut_scan_accumulate import nlsa_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  logic [2*WORD_W-1:0] codes;
  lut_t                lut;
  sum_arr_t            lane_sums;
  lane_ctl_t           lane_ctl;
  logic                busy;
  logic                in_xfer;

  assign codes    = {in_data.code_bytes_hi, in_data.code_bytes_lo};
  assign lut      = lut_t'({in_data.table_entries_hi, in_data.table_entries_lo});
  assign in_ready = !busy || !in_data.final_step;
  assign in_xfer  = in_valid && in_ready;

  assign lane_ctl.en  = in_xfer;
  assign lane_ctl.clr = in_data.final_step;

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    localparam int J  = l % GROUP_LANES;
    localparam int G  = l / GROUP_LANES;
    localparam int K  = 2 * J + (G % 2);
    localparam int SH = BYTE_W * K + NIB_W * (G / 2);

    nlsa_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl_i (lane_ctl),
      .nib_i (codes[SH +: NIB_W]),
      .lut_i (lut),
      .sum_o (lane_sums[l])
    );
  end

  nlsa_drain u_drain (
    .clk       (clk),
    .rst_n     (rst_n),
    .load_i    (in_xfer && in_data.final_step),
    .sums_i    (lane_sums),
    .busy_o    (busy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> sv/nlsa_checker.sv
// Port-level checks for the nibble lookup scan accumulator, bound to the top level.
// Depends on nlsa_pkg and nibble_lut_scan_accumulate_defines.svh.
`include "nibble_lut_scan_accumulate_defines.svh"

module nlsa_checker import nlsa_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input in_t  in_data,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  `NLSA_ASSERT_NOW(a_run_end_last, clk, rst_n, out_valid, out_data.run_end == (out_data.lane_index == LANE_LAST), "run_end must mark lane 31 only")
  `NLSA_ASSERT_NEXT(a_index_advance, clk, rst_n, out_valid && out_ready && !out_data.run_end, out_valid && out_data.lane_index == $past(out_data.lane_index) + IDX_W'(1), "lane index must advance by one")
  `NLSA_ASSERT_NEXT(a_gap_after_end, clk, rst_n, out_valid && out_ready && out_data.run_end, !out_valid, "no result may follow run_end in the next cycle")
  `NLSA_ASSERT_NOW(a_final_held, clk, rst_n, in_valid && in_data.final_step && out_valid, !in_ready, "final step must wait for the drain")

endmodule

bind nibble_lut_scan_accumulate nlsa_checker u_nlsa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
